// ===== rtl/tem_pkg.sv =====
package tem_pkg;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned TABLE_AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam int unsigned OPQ_DEPTH = 4;
  localparam int unsigned OPQ_AW    = $clog2(OPQ_DEPTH);
  localparam int unsigned OPQ_CW    = $clog2(OPQ_DEPTH + 1);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [7:0] CHAR_NUL     = 8'd0;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MARGIN          = 3'd0,
    CFG_CHAR_EXTRA      = 3'd1,
    CFG_END_ADJUST      = 3'd2,
    CFG_LINE_ADVANCE    = 3'd3,
    CFG_UNDERLINE_EXTRA = 3'd4,
    CFG_FIRST_GLYPH     = 3'd5,
    CFG_GLYPH_COUNT     = 3'd6,
    CFG_DEFAULT_GLYPH   = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_GLYPH   = 2'd0,
    OP_NEWLINE = 2'd1,
    OP_NUL     = 2'd2
  } op_kind_e;

  typedef struct packed {
    logic [3:0] margin;
    logic [7:0] char_extra;
    logic [8:0] end_adjust;
    logic [7:0] line_advance;
    logic [7:0] underline_extra;
    logic [7:0] first_glyph;
    logic [8:0] glyph_count;
    logic [7:0] default_glyph;
  } cfg_t;

  typedef struct packed {
    logic       command;
    logic [7:0] table_index;
    logic [7:0] advance_width;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] text_width;
    logic signed [15:0] text_height;
  } out_item_t;

  typedef struct packed {
    op_kind_e   kind;
    logic [7:0] advance;
  } op_t;

endpackage

// ===== rtl/tem_front.sv =====
module tem_front import tem_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     accept_i,
  input  in_item_t item_i,
  output logic     s1_valid_o,
  output op_t      op_o,
  input  logic     op_taken_i
);

  logic [7:0]          mem_q [TABLE_DEPTH];
  logic [7:0]          rdata_q;
  logic                s1_valid_q, s1_valid_d;
  op_kind_e            kind_q;
  logic                oob_q;

  logic [8:0]          diff;
  logic                in_range;
  logic [7:0]          slot;
  logic                slot_oob;
  logic                load_ok;
  logic                char_acc;
  op_kind_e            kind_d;

  always_comb begin
    diff     = {1'b0, item_i.char_code} - {1'b0, cfg_i.first_glyph};
    in_range = !diff[8] && ({1'b0, diff[7:0]} < cfg_i.glyph_count);
    slot     = in_range ? diff[7:0] : (cfg_i.default_glyph - cfg_i.first_glyph);
    slot_oob = ({1'b0, slot} >= 9'(TABLE_DEPTH));
    load_ok  = ({1'b0, item_i.table_index} < 9'(TABLE_DEPTH));
    char_acc = accept_i && item_i.command;
    if (item_i.char_code == CHAR_NUL) begin
      kind_d = OP_NUL;
    end else if (item_i.char_code == CHAR_NEWLINE) begin
      kind_d = OP_NEWLINE;
    end else begin
      kind_d = OP_GLYPH;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && !item_i.command && load_ok) begin
      mem_q[item_i.table_index[TABLE_AW-1:0]] <= item_i.advance_width;
    end
    if (char_acc) begin
      rdata_q <= mem_q[slot[TABLE_AW-1:0]];
      kind_q  <= kind_d;
      oob_q   <= slot_oob;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (op_taken_i) begin
      s1_valid_d = 1'b0;
    end
    if (char_acc) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  assign s1_valid_o  = s1_valid_q;
  assign op_o.kind    = kind_q;
  assign op_o.advance = oob_q ? 8'd0 : rdata_q;

endmodule

// ===== rtl/tem_op_queue.sv =====
module tem_op_queue import tem_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  op_t  op_i,
  output logic full_o,
  input  logic rd_i,
  output op_t  op_o,
  output logic empty_o
);

  op_t               buf_q [OPQ_DEPTH];
  logic [OPQ_AW-1:0] wptr_q, wptr_d;
  logic [OPQ_AW-1:0] rptr_q, rptr_d;
  logic [OPQ_CW-1:0] cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr_i) begin
      wptr_d = (wptr_q == OPQ_AW'(OPQ_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (rd_i) begin
      rptr_d = (rptr_q == OPQ_AW'(OPQ_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_i && rd_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      buf_q[wptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  assign full_o  = (cnt_q == OPQ_CW'(OPQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign op_o    = buf_q[rptr_q];

endmodule

// ===== rtl/tem_back.sv =====
module tem_back import tem_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      op_valid_i,
  input  op_t       op_i,
  output logic      op_take_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t item_o
);

  logic [15:0] lw_q, lw_d;
  logic [15:0] wl_q, wl_d;
  logic [15:0] ht_q, ht_d;
  logic        start_q, start_d;

  out_item_t   obuf_q [2];
  logic        owp_q, orp_q;
  logic [1:0]  ocnt_q, ocnt_d;
  logic        out_full;
  logic        out_wr;
  logic        out_rd;

  logic [15:0] start_val;
  logic [15:0] lw_b, wl_b, ht_b;
  logic [15:0] widest;
  out_item_t   res;

  assign out_full  = (ocnt_q == 2'd2);
  assign op_take_o = op_valid_i && ((op_i.kind != OP_NUL) || !out_full);
  assign out_wr    = op_take_o && (op_i.kind == OP_NUL);
  assign out_rd    = pop_i && (ocnt_q != 2'd0);

  always_comb begin
    start_val = {11'd0, cfg_i.margin, 1'b0};
    if (start_q) begin
      lw_b = start_val;
      ht_b = start_val + {8'd0, cfg_i.underline_extra};
      wl_b = '0;
    end else begin
      lw_b = lw_q;
      ht_b = ht_q;
      wl_b = wl_q;
    end
    widest = ($signed(lw_q) < $signed(wl_q)) ? wl_q : lw_q;
    res.text_width  = start_q ? '0 : widest + {{7{cfg_i.end_adjust[8]}}, cfg_i.end_adjust};
    res.text_height = start_q ? '0 : ht_q;

    lw_d    = lw_q;
    wl_d    = wl_q;
    ht_d    = ht_q;
    start_d = start_q;
    if (op_take_o) begin
      case (op_i.kind)
        OP_NUL: begin
          start_d = 1'b1;
        end
        OP_NEWLINE: begin
          start_d = 1'b0;
          ht_d    = ht_b + {8'd0, cfg_i.line_advance};
          wl_d    = ($signed(lw_b) > $signed(wl_b)) ? lw_b : wl_b;
          lw_d    = start_val;
        end
        OP_GLYPH: begin
          start_d = 1'b0;
          ht_d    = ht_b;
          wl_d    = wl_b;
          lw_d    = lw_b + {8'd0, op_i.advance} + {8'd0, cfg_i.char_extra};
        end
        default: begin
          start_d = start_q;
        end
      endcase
    end

    ocnt_d = ocnt_q;
    if (out_wr && !out_rd) begin
      ocnt_d = ocnt_q + 1'b1;
    end else if (!out_wr && out_rd) begin
      ocnt_d = ocnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_wr) begin
      obuf_q[owp_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q    <= '0;
      wl_q    <= '0;
      ht_q    <= '0;
      start_q <= 1'b1;
      owp_q   <= 1'b0;
      orp_q   <= 1'b0;
      ocnt_q  <= '0;
    end else begin
      lw_q    <= lw_d;
      wl_q    <= wl_d;
      ht_q    <= ht_d;
      start_q <= start_d;
      ocnt_q  <= ocnt_d;
      if (out_wr) begin
        owp_q <= ~owp_q;
      end
      if (out_rd) begin
        orp_q <= ~orp_q;
      end
    end
  end

  assign empty_o = (ocnt_q == 2'd0);
  assign item_o  = obuf_q[orp_q];

endmodule

// ===== rtl/text_extent_measure.sv =====
// channel  | handshake          | payload
// ---------+--------------------+-------------------------------
// input    | push / full        | in_item_i  (in_item_t)
// result   | pop / empty        | out_item_o (out_item_t)
// config   | cfg_we_i           | cfg_idx_i, cfg_wdata_i
//
// One transaction per cycle is accepted while full is low; a result passes the table read
// register, the op queue and the result queue after its NUL character is accepted.
// The front registers the table read; the back accumulates one op per cycle unless stalled.
// Reset clears control and measurement state; the advance table holds garbage until loaded.
// full rises only when the op queue is full and the front holds a character;
// the back stalls on a NUL while both result entries wait.
module text_extent_measure import tem_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  push,
  output logic                  full,
  input  in_item_t              in_item_i,
  output logic                  empty,
  input  logic                  pop,
  output out_item_t             out_item_o
);

  cfg_t cfg_q;
  logic accept;
  logic s1_valid;
  op_t  s1_op;
  logic opq_full;
  logic opq_empty;
  logic opq_wr;
  logic opq_rd;
  op_t  opq_op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.margin          <= 4'd2;
      cfg_q.char_extra      <= 8'd0;
      cfg_q.end_adjust      <= 9'd0;
      cfg_q.line_advance    <= 8'd16;
      cfg_q.underline_extra <= 8'd0;
      cfg_q.first_glyph     <= 8'd32;
      cfg_q.glyph_count     <= 9'd96;
      cfg_q.default_glyph   <= 8'd32;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MARGIN:          cfg_q.margin          <= cfg_wdata_i[3:0];
        CFG_CHAR_EXTRA:      cfg_q.char_extra      <= cfg_wdata_i[7:0];
        CFG_END_ADJUST:      cfg_q.end_adjust      <= cfg_wdata_i[8:0];
        CFG_LINE_ADVANCE:    cfg_q.line_advance    <= cfg_wdata_i[7:0];
        CFG_UNDERLINE_EXTRA: cfg_q.underline_extra <= cfg_wdata_i[7:0];
        CFG_FIRST_GLYPH:     cfg_q.first_glyph     <= cfg_wdata_i[7:0];
        CFG_GLYPH_COUNT:     cfg_q.glyph_count     <= cfg_wdata_i[8:0];
        CFG_DEFAULT_GLYPH:   cfg_q.default_glyph   <= cfg_wdata_i[7:0];
        default:             cfg_q.margin          <= cfg_q.margin;
      endcase
    end
  end

  assign full   = s1_valid && opq_full;
  assign accept = push && !full;
  assign opq_wr = s1_valid && !opq_full;

  tem_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .accept_i   (accept),
    .item_i     (in_item_i),
    .s1_valid_o (s1_valid),
    .op_o       (s1_op),
    .op_taken_i (opq_wr)
  );

  tem_op_queue u_op_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (opq_wr),
    .op_i    (s1_op),
    .full_o  (opq_full),
    .rd_i    (opq_rd),
    .op_o    (opq_op),
    .empty_o (opq_empty)
  );

  tem_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .op_valid_i (!opq_empty),
    .op_i       (opq_op),
    .op_take_o  (opq_rd),
    .empty_o    (empty),
    .pop_i      (pop),
    .item_o     (out_item_o)
  );

endmodule
